### rtl/mrfp_pkg.sv
// ---------------------------------------------------------------------------
// Meter response frame parser: shared types and constants
// Command codes, status codes, frame layout and the CRC-16/MODBUS byte update.
// ---------------------------------------------------------------------------
package mrfp_pkg;

    // request codes on the input tuser
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // classified command codes held in the queue
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_CRC     = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    localparam int          FRAME_BYTES   = 25;
    localparam int          PAYLOAD_FIRST = 3;
    localparam int          PAYLOAD_DEPTH = 20;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam int          OUT_DATA_W    = 184;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] volt_tenths;
        logic [31:0] amp_milli;
        logic [31:0] watt_tenths;
        logic [31:0] energy_total;
        logic [15:0] freq_tenths;
        logic [15:0] pf_hundredths;
        logic [15:0] alarm_word;
        logic [4:0]  bytes_received;
    } result_t;

    // one byte of CRC-16/MODBUS, reflected, unrolled over eight bit steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### rtl/mrfp_front.sv
// ---------------------------------------------------------------------------
// Meter response frame parser: front end
// Takes input beats, sorts them into start, byte and tick commands and
// pushes them into the command queue. Unknown request codes are dropped.
// ---------------------------------------------------------------------------
module mrfp_front
    import mrfp_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic [1:0] s_tuser,   // [1:0] req_type
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic keep;

    always_comb
    begin
        keep        = 1'b1;
        q_cmd.data  = s_tdata;
        q_cmd.kind  = CMD_START;
        unique case (s_tuser)
            REQ_START: q_cmd.kind = CMD_START;
            REQ_BYTE:  q_cmd.kind = CMD_BYTE;
            REQ_TICK:  q_cmd.kind = CMD_TICK;
            default:   keep       = 1'b0;
        endcase
    end

    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & s_tready & keep;

endmodule

### rtl/mrfp_queue.sv
// ---------------------------------------------------------------------------
// Meter response frame parser: command queue
// Small register FIFO between the front end and the frame engine.
// ---------------------------------------------------------------------------
module mrfp_queue
    import mrfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/mrfp_back.sv
// ---------------------------------------------------------------------------
// Meter response frame parser: frame engine
// Runs one queued command a cycle while the output slot is free: frame state,
// CRC, payload capture, timeout count and the registered result beat.
// ---------------------------------------------------------------------------
module mrfp_back
    import mrfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        q_not_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_result
);

    logic [15:0] timeout_reg;
    logic        receiving_reg,  receiving_next;
    logic [4:0]  byte_count_reg, byte_count_next;
    logic [15:0] elapsed_reg,    elapsed_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  crc_low_reg;
    logic [7:0]  payload_reg [PAYLOAD_DEPTH];
    logic        out_valid_reg,  out_valid_next;
    result_t     result_reg;

    logic        emit;
    logic [1:0]  emit_status;
    logic [15:0] elapsed_inc;
    logic        crc_low_we;
    logic        payload_we;
    logic [4:0]  payload_idx;
    result_t     result_new;

    // pop whenever the output slot is free or being emptied this cycle
    assign q_pop       = q_not_empty & (~out_valid_reg | out_ready);
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign payload_idx = byte_count_reg - 5'(PAYLOAD_FIRST);

    always_comb
    begin
        receiving_next  = receiving_reg;
        byte_count_next = byte_count_reg;
        elapsed_next    = elapsed_reg;
        crc_next        = crc_reg;
        crc_low_we      = 1'b0;
        payload_we      = 1'b0;
        emit            = 1'b0;
        emit_status     = STATUS_GOOD;

        if (q_pop)
        begin
            if (q_cmd.kind == CMD_START)
            begin
                receiving_next  = 1'b1;
                byte_count_next = '0;
                elapsed_next    = '0;
                crc_next        = CRC_INIT;
            end
            else if (receiving_reg)
            begin
                if (q_cmd.kind == CMD_TICK)
                begin
                    if (elapsed_inc >= timeout_reg)
                    begin
                        emit        = 1'b1;
                        emit_status = STATUS_TIMEOUT;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                else if (elapsed_reg >= timeout_reg)
                begin
                    // timeout lowered mid-frame: byte dropped
                    emit        = 1'b1;
                    emit_status = STATUS_TIMEOUT;
                end
                else if (byte_count_reg < 5'(FRAME_BYTES - 2))
                begin
                    crc_next        = crc16_byte(crc_reg, q_cmd.data);
                    payload_we      = (byte_count_reg >= 5'(PAYLOAD_FIRST));
                    byte_count_next = byte_count_reg + 5'd1;
                end
                else if (byte_count_reg == 5'(FRAME_BYTES - 2))
                begin
                    crc_low_we      = 1'b1;
                    byte_count_next = byte_count_reg + 5'd1;
                end
                else
                begin
                    emit        = 1'b1;
                    emit_status = (crc_reg == {q_cmd.data, crc_low_reg}) ? STATUS_GOOD
                                                                         : STATUS_CRC;
                end
            end
            if (emit)
            begin
                receiving_next  = 1'b0;
                byte_count_next = '0;
                elapsed_next    = '0;
                crc_next        = CRC_INIT;
            end
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // result fields; measurements only on a good frame
    always_comb
    begin
        result_new                = '0;
        result_new.status         = emit_status;
        result_new.bytes_received = (emit_status == STATUS_TIMEOUT) ? byte_count_reg
                                                                    : 5'(FRAME_BYTES);
        if (emit_status == STATUS_GOOD)
        begin
            result_new.volt_tenths   = {payload_reg[0],  payload_reg[1]};
            result_new.amp_milli     = {payload_reg[4],  payload_reg[5],
                                        payload_reg[2],  payload_reg[3]};
            result_new.watt_tenths   = {payload_reg[8],  payload_reg[9],
                                        payload_reg[6],  payload_reg[7]};
            result_new.energy_total  = {payload_reg[12], payload_reg[13],
                                        payload_reg[10], payload_reg[11]};
            result_new.freq_tenths   = {payload_reg[14], payload_reg[15]};
            result_new.pf_hundredths = {payload_reg[16], payload_reg[17]};
            result_new.alarm_word    = {payload_reg[18], payload_reg[19]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            receiving_reg  <= 1'b0;
            byte_count_reg <= '0;
            elapsed_reg    <= '0;
            crc_reg        <= CRC_INIT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                timeout_reg <= cfg_data;
            end
            receiving_reg  <= receiving_next;
            byte_count_reg <= byte_count_next;
            elapsed_reg    <= elapsed_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (crc_low_we)
        begin
            crc_low_reg <= q_cmd.data;
        end
        if (payload_we)
        begin
            payload_reg[payload_idx] <= q_cmd.data;
        end
        if (emit)
        begin
            result_reg <= result_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

### rtl/meter_response_frame_parser_core.sv
// ---------------------------------------------------------------------------
// Meter response frame parser core
// Receives a 25-byte read-input-registers reply, checks CRC-16/MODBUS and
// gives the decoded measurements, a CRC status or a timeout status.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser req_type, tdata rx_byte
//  m_*       out        m_tvalid / m_tready  tuser status, tdata measurements
//  cfg_*     in         cfg_valid/cfg_ready  cfg_data frame time limit, ms
//
//  One beat a cycle sustained while m_tready keeps up; each command is held
//  in the queue register and runs in the frame engine once the output slot is
//  free, and the result beat is registered. The byte-wide CRC update sets the path.
//  Reset: idle, timeout 100 ms. A stalled m_tready fills the queue, after
//  which s_tready drops; config writes are always taken.
// ---------------------------------------------------------------------------
module meter_response_frame_parser_core
    import mrfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic [1:0]            s_tuser,   // [1:0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] volt_tenths, [47:16] amp_milli, [79:48] watt_tenths,
    // [111:80] energy_total, [127:112] freq_tenths, [143:128] pf_hundredths,
    // [159:144] alarm_word, [164:160] bytes_received, rest zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,   // [1:0] status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);

    logic    q_push, q_full, q_pop, q_not_empty;
    cmd_t    push_cmd, pop_cmd;
    result_t result;

    mrfp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    mrfp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    mrfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid & cfg_ready),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    assign cfg_ready = 1'b1;
    assign m_tuser   = result.status;
    assign m_tdata   = {19'd0,
                        result.bytes_received,
                        result.alarm_word,
                        result.pf_hundredths,
                        result.freq_tenths,
                        result.energy_total,
                        result.watt_tenths,
                        result.amp_milli,
                        result.volt_tenths};

endmodule

### bench/meter_response_frame_parser_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Meter response frame parser core: self-checking testbench
// Streams starts, frame bytes, millisecond ticks and stray requests into the
// parser and checks every result beat against a behavioural predictor of
// the frame receiver. Good, corrupted, cut-short and timed-out frames are
// covered under several timeout settings, with random idling on both sides.
// ---------------------------------------------------------------------------
module meter_response_frame_parser_core_tb
    import mrfp_pkg::*;
;

    localparam int         CLK_PERIOD     = 20;
    localparam int         RESET_CYCLES   = 10;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         HOLD_CYCLES    = 120;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         PHASE_REQUESTS = 95;
    localparam int         NUM_PHASES     = 7;
    localparam logic [1:0] REQ_SPARE      = 2'd3;   // unused request code
    localparam int         FILL_ZERO      = 0;
    localparam int         FILL_ONES      = 1;
    localparam int         FILL_RANDOM    = 2;

    // predictor of the frame receiver plus the queue of results it expects
    class frame_scoreboard;
        logic [15:0] limit_ms;
        bit          receiving;
        logic [4:0]  byte_count;
        logic [15:0] elapsed_ms;
        logic [15:0] crc;
        logic [7:0]  crc_low;
        logic [7:0]  payload [PAYLOAD_DEPTH];
        result_t     expected_q [$];
        int          errors;

        function new();
            limit_ms = TIMEOUT_RESET;
            errors   = 0;
            crc_low  = 8'h00;
            foreach (payload[i])
                payload[i] = 8'h00;
            go_idle();
        endfunction

        static function logic [15:0] crc_after(logic [15:0] c, logic [7:0] b);
            c = c ^ {8'h00, b};
            repeat (8)
                c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
            return c;
        endfunction

        function void go_idle();
            receiving  = 1'b0;
            byte_count = 5'd0;
            elapsed_ms = 16'd0;
            crc        = CRC_INIT;
        endfunction

        function void load_limit(logic [15:0] value);
            limit_ms = value;
        endfunction

        // status-only result: measurements zero
        function void post_empty(logic [1:0] st);
            result_t r;
            r                = '0;
            r.status         = st;
            r.bytes_received = byte_count;
            expected_q.push_back(r);
            go_idle();
        endfunction

        function void note_request(logic [1:0] kind, logic [7:0] data);
            result_t r;
            if (kind == REQ_START)
            begin
                go_idle();
                receiving = 1'b1;
                return;
            end
            if (!receiving)
                return;
            if (kind == REQ_TICK)
            begin
                if (elapsed_ms != 16'hFFFF)
                    elapsed_ms++;
                if (elapsed_ms >= limit_ms)
                    post_empty(STATUS_TIMEOUT);
                return;
            end
            if (kind != REQ_BYTE)
                return;
            // limit lowered mid-frame: byte dropped
            if (elapsed_ms >= limit_ms)
            begin
                post_empty(STATUS_TIMEOUT);
                return;
            end
            if (byte_count < FRAME_BYTES - 2)
            begin
                crc = crc_after(crc, data);
                if (byte_count >= PAYLOAD_FIRST)
                    payload[byte_count - PAYLOAD_FIRST] = data;
                byte_count++;
            end
            else if (byte_count == FRAME_BYTES - 2)
            begin
                crc_low = data;
                byte_count++;
            end
            else
            begin
                byte_count = 5'(FRAME_BYTES);
                if (crc != {data, crc_low})
                begin
                    post_empty(STATUS_CRC);
                end
                else
                begin
                    r                = '0;
                    r.status         = STATUS_GOOD;
                    r.volt_tenths    = {payload[0], payload[1]};
                    r.amp_milli      = {payload[4], payload[5], payload[2], payload[3]};
                    r.watt_tenths    = {payload[8], payload[9], payload[6], payload[7]};
                    r.energy_total   = {payload[12], payload[13], payload[10], payload[11]};
                    r.freq_tenths    = {payload[14], payload[15]};
                    r.pf_hundredths  = {payload[16], payload[17]};
                    r.alarm_word     = {payload[18], payload[19]};
                    r.bytes_received = byte_count;
                    expected_q.push_back(r);
                    go_idle();
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t  %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [OUT_DATA_W-1:0] d);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t  unexpected result: expected none, actual status %0d data 0x%0h",
                         $time, st, d);
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 32'(want.status), 32'(st));
            compare_field("volt_tenths", 32'(want.volt_tenths), 32'(d[15:0]));
            compare_field("amp_milli", want.amp_milli, d[47:16]);
            compare_field("watt_tenths", want.watt_tenths, d[79:48]);
            compare_field("energy_total", want.energy_total, d[111:80]);
            compare_field("freq_tenths", 32'(want.freq_tenths), 32'(d[127:112]));
            compare_field("pf_hundredths", 32'(want.pf_hundredths), 32'(d[143:128]));
            compare_field("alarm_word", 32'(want.alarm_word), 32'(d[159:144]));
            compare_field("bytes_received", 32'(want.bytes_received), 32'(d[164:160]));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [15:0]           cfg_data;

    logic steady  = 1'b0;   // no idling on either side
    logic hold_on = 1'b0;   // receiver long hold-off request
    int   requests_sent = 0;
    int   quiet_cycles  = 0;

    frame_scoreboard sb = new();

    meter_response_frame_parser_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // beat monitors
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.load_limit(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t  watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("[meter_response_frame_parser_core] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off when asked
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_on && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (steady)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= 28);
            end
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [7:0] data);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 28)
                gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // drain: all expected results out, then let any trailing beat finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int fill, input bit spoil);
        logic [7:0]  frm [FRAME_BYTES];
        logic [15:0] c;
        int          lim;
        int          ticks_left;
        c = CRC_INIT;
        frm[0] = 8'($urandom_range(255));
        frm[1] = 8'h04;
        frm[2] = 8'd20;
        for (int i = PAYLOAD_FIRST; i < FRAME_BYTES - 2; i++)
        begin
            case (fill)
                FILL_ZERO: frm[i] = 8'h00;
                FILL_ONES: frm[i] = 8'hFF;
                default:   frm[i] = 8'($urandom_range(255));
            endcase
        end
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            c = frame_scoreboard::crc_after(c, frm[i]);
        frm[FRAME_BYTES - 2] = c[7:0];
        frm[FRAME_BYTES - 1] = c[15:8];
        if (spoil)
            frm[$urandom_range(FRAME_BYTES - 1)] ^= 8'h01 << $urandom_range(7);
        // ticks kept under the limit so that an intact frame completes when the limit is above zero
        lim = (sb.limit_ms > 16'd4) ? 4 : int'(sb.limit_ms) - 1;
        ticks_left = (lim > 0) ? int'($urandom_range(lim)) : 0;
        send_request(REQ_START, 8'($urandom_range(255)));
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (ticks_left > 0 && $urandom_range(7) == 0)
            begin
                send_request(REQ_TICK, 8'($urandom_range(255)));
                ticks_left--;
            end
            send_request(REQ_BYTE, frm[i]);
        end
    endtask

    task automatic random_sequence();
        int pick;
        int fill;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            fill = $urandom_range(9);
            fill = (fill == 0) ? FILL_ZERO : (fill == 1) ? FILL_ONES : FILL_RANDOM;
            send_frame(fill, $urandom_range(4) == 0);
        end
        else if (pick < 75)
        begin
            // cut short by the timeout for a limit of 40 or less, then stray bytes (ignored once timed out)
            send_request(REQ_START, 8'($urandom_range(255)));
            repeat ($urandom_range(24)) send_request(REQ_BYTE, 8'($urandom_range(255)));
            if (sb.limit_ms <= 16'd40)
                repeat ((sb.limit_ms == 16'd0) ? 1 : int'(sb.limit_ms))
                    send_request(REQ_TICK, 8'($urandom_range(255)));
            else
                repeat ($urandom_range(1, 3)) send_request(REQ_TICK, 8'($urandom_range(255)));
            repeat ($urandom_range(2)) send_request(REQ_BYTE, 8'($urandom_range(255)));
        end
        else if (pick < 85)
        begin
            // partial frame, left for the next start to restart
            send_request(REQ_START, 8'($urandom_range(255)));
            repeat ($urandom_range(1, 24)) send_request(REQ_BYTE, 8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        logic [15:0] limit;
        int          phase_start;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = REQ_START;
        cfg_valid = 1'b0;
        cfg_data  = 16'h0000;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle requests and the unused code are ignored
        send_request(REQ_BYTE, 8'hA5);
        send_request(REQ_TICK, 8'h5A);
        send_request(REQ_SPARE, 8'hFF);
        settle();
        write_timeout(16'd0);
        send_request(REQ_START, 8'h00);
        send_request(REQ_TICK, 8'h00);
        settle();
        write_timeout(16'hFFFF);
        send_request(REQ_START, 8'h00);
        send_request(REQ_BYTE, 8'h00);
        send_request(REQ_BYTE, 8'hFF);
        send_request(REQ_START, 8'hFF);   // restart mid-frame
        send_request(REQ_BYTE, 8'h12);
        send_request(REQ_BYTE, 8'h34);
        repeat (3) send_request(REQ_TICK, 8'h00);
        settle();
        // limit drops below elapsed time mid-frame: next byte times out
        write_timeout(16'd2);
        send_request(REQ_BYTE, 8'hC3);
        send_request(REQ_BYTE, 8'h3C);
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       limit = 16'd1;
                1:       limit = 16'hFFFF;
                2:       limit = 16'd5;
                3:       limit = 16'($urandom_range(2, 40));
                4:       limit = 16'd0;
                5:       limit = 16'($urandom_range(16'hFFFF));
                default: limit = TIMEOUT_RESET;
            endcase
            write_timeout(limit);
            steady <= (p == 1);
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS)
                random_sequence();
            settle();
        end
        steady <= 1'b0;

        // long receiver hold-off while timeouts keep coming: input backs up
        write_timeout(16'd1);
        steady  <= 1'b1;
        hold_on <= 1'b1;
        repeat (30)
        begin
            send_request(REQ_START, 8'($urandom_range(255)));
            send_request(REQ_TICK, 8'($urandom_range(255)));
        end
        steady  <= 1'b0;
        hold_on <= 1'b0;
        settle();

        if (sb.expected_q.size() != 0)
        begin
            sb.errors++;
            $display("%0t  %0d expected results never arrived", $time, sb.expected_q.size());
        end
        if (sb.errors == 0)
        begin
            $display("[meter_response_frame_parser_core] OK");
        end
        else
        begin
            $display("[meter_response_frame_parser_core] ERROR");
        end
        $finish;
    end

endmodule
